@@ sv/sacl_pkg.sv @@
`timescale 1ns / 1ps

package sacl_pkg;

  // Default geometry of the cache.
  localparam int DEF_WAYS        = 4;
  localparam int DEF_SETS        = 512;
  localparam int DEF_BLOCK_BYTES = 8;

  // Fixed widths of the request and result fields.
  localparam int ADDR_W    = 32;
  localparam int RWAY_W    = 2;
  localparam int OUT_WAY_W = 2;
  localparam int CNT_W     = 32;
  localparam int STAMP_W   = 32;
  localparam int MODE_W    = 2;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_MODE = 1'b0;

  // Replacement policies. Code 3 behaves like random.
  localparam logic [MODE_W-1:0] MODE_FIFO   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LRU    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd2;

  // Depth of the request queue between front and back.
  localparam int RQ_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_COMMIT
  } back_state_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
  } res_t;

endpackage

@@ sv/sacl_front.sv @@
`timescale 1ns / 1ps

module sacl_front #(
  parameter int WAYS        = 4,
  parameter int SETS        = 512,
  parameter int BLOCK_BYTES = 8,
  localparam int OFF   = 2 + $clog2(BLOCK_BYTES / 4),
  localparam int IBITS = $clog2(SETS),
  localparam int SET_W = (IBITS > 0) ? IBITS : 1,
  localparam int TAG_W = 32 - OFF - IBITS,
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_i,
  input  logic                        block_i,
  output logic                        full_o,
  input  logic [sacl_pkg::ADDR_W-1:0] address_i,
  input  logic [sacl_pkg::RWAY_W-1:0] random_way_i,
  output logic                        req_valid_o,
  input  logic                        req_take_i,
  output logic [SET_W-1:0]            req_set_o,
  output logic [TAG_W-1:0]            req_tag_o,
  output logic [WAY_W-1:0]            req_rway_o
);
  import sacl_pkg::*;

  localparam int PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(RQ_DEPTH + 1);

  logic [SET_W-1:0]  dec_set;
  logic [TAG_W-1:0]  dec_tag;
  logic [WAY_W-1:0]  dec_rway;
  logic [2:0]        rway_mod;

  logic [SET_W-1:0]  q_set_r  [RQ_DEPTH];
  logic [TAG_W-1:0]  q_tag_r  [RQ_DEPTH];
  logic [WAY_W-1:0]  q_rway_r [RQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push_ok;
  logic              take_ok;

  // Split the address into set index and tag.
  generate
    if (IBITS > 0) begin : g_idx
      logic [SET_W-1:0] set_raw;
      assign set_raw = address_i[OFF +: IBITS];
      // The raw field is below twice SETS, so one subtract reduces it.
      always_comb begin
        if (32'(set_raw) >= 32'(SETS)) begin
          dec_set = SET_W'(32'(set_raw) - 32'(SETS));
        end else begin
          dec_set = set_raw;
        end
      end
    end else begin : g_noidx
      assign dec_set = '0;
    end
  endgenerate

  assign dec_tag = address_i[ADDR_W-1 -: TAG_W];

  // The random way is only two bits wide, so a few subtracts reduce it.
  always_comb begin
    rway_mod = 3'(random_way_i);
    for (int k = 0; k < 3; k++) begin
      if (int'(rway_mod) >= WAYS) begin
        rway_mod = 3'(int'(rway_mod) - WAYS);
      end
    end
  end

  assign dec_rway = WAY_W'(rway_mod);

  assign full_o      = (count_r == QCNT_W'(RQ_DEPTH)) || block_i;
  assign push_ok     = push_i && !full_o;
  assign req_valid_o = (count_r != '0);
  assign take_ok     = req_take_i && req_valid_o;

  assign req_set_o  = q_set_r[rd_ptr_r];
  assign req_tag_o  = q_tag_r[rd_ptr_r];
  assign req_rway_o = q_rway_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (take_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !take_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_ok && take_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_set_r[wr_ptr_r]  <= dec_set;
      q_tag_r[wr_ptr_r]  <= dec_tag;
      q_rway_r[wr_ptr_r] <= dec_rway;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(RQ_DEPTH))
    else $error("request queue holds more entries than its depth");

  a_take_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    req_take_i |-> req_valid_o)
    else $error("back end took a request from an empty queue");

endmodule

@@ sv/sacl_back.sv @@
`timescale 1ns / 1ps

module sacl_back #(
  parameter int WAYS        = 4,
  parameter int SETS        = 512,
  parameter int BLOCK_BYTES = 8,
  localparam int OFF   = 2 + $clog2(BLOCK_BYTES / 4),
  localparam int IBITS = $clog2(SETS),
  localparam int SET_W = (IBITS > 0) ? IBITS : 1,
  localparam int TAG_W = 32 - OFF - IBITS,
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sacl_pkg::MODE_W-1:0] mode_i,
  input  logic                        req_valid_i,
  input  logic [SET_W-1:0]            req_set_i,
  input  logic [TAG_W-1:0]            req_tag_i,
  input  logic [WAY_W-1:0]            req_rway_i,
  output logic                        req_take_o,
  output logic                        clearing_o,
  input  logic                        pop_i,
  output logic                        out_valid_o,
  output sacl_pkg::res_t              out_res_o
);
  import sacl_pkg::*;

  back_state_t state_r, state_nxt;

  // Tag store, one row per set holding every way.
  logic [WAYS-1:0]               mem_v [SETS];
  logic [WAYS-1:0][TAG_W-1:0]    mem_t [SETS];
  logic [WAYS-1:0][STAMP_W-1:0]  mem_s [SETS];
  logic [WAYS-1:0]               rd_v_r;
  logic [WAYS-1:0][TAG_W-1:0]    rd_t_r;
  logic [WAYS-1:0][STAMP_W-1:0]  rd_s_r;
  logic                          rd_en;
  logic                          mem_we;
  logic [SET_W-1:0]              mem_addr;
  logic [WAYS-1:0]               wr_v;
  logic [WAYS-1:0][TAG_W-1:0]    wr_t;
  logic [WAYS-1:0][STAMP_W-1:0]  wr_s;

  logic [SET_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [SET_W-1:0]   cur_set_r;
  logic [TAG_W-1:0]   cur_tag_r;
  logic [WAY_W-1:0]   cur_rway_r;
  logic [WAY_W-1:0]   used_r, used_nxt;
  logic               hit_r, hit_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic [WAY_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   hits_r, hits_nxt;
  logic [CNT_W-1:0]   misses_r, misses_nxt;
  logic [STAMP_W-1:0] fill_r, fill_nxt;
  logic [STAMP_W-1:0] access_r, access_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  logic [WAYS-1:0]    hit_vec;
  logic               look_hit;
  logic [WAY_W-1:0]   hit_way;
  logic               any_inv;
  logic [WAY_W-1:0]   inv_way;
  logic               mode_age;
  logic               dec_ready;
  logic [WAY_W-1:0]   dec_used;
  logic [STAMP_W-1:0] scan_stamp;
  logic               scan_less;
  logic               slot_free;
  logic               commit;
  logic [WAY_W-1:0]   commit_used;
  logic               commit_hit;

  // Tag compare and the lowest matching and lowest empty way.
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = rd_v_r[w] && (rd_t_r[w] == cur_tag_r);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!rd_v_r[w]) begin
        inv_way = WAY_W'(w);
      end
    end
  end

  assign look_hit = |hit_vec;
  assign any_inv  = ~&rd_v_r;
  assign mode_age = (mode_i == MODE_FIFO) || (mode_i == MODE_LRU);

  // Victim decision that is known in the lookup cycle. An aged eviction
  // with more than one way needs the stamp scan instead.
  always_comb begin
    dec_ready = 1'b1;
    dec_used  = '0;
    priority if (look_hit) begin
      dec_used = hit_way;
    end else if (any_inv) begin
      dec_used = inv_way;
    end else if (!mode_age) begin
      dec_used = cur_rway_r;
    end else if (WAYS == 1) begin
      dec_used = '0;
    end else begin
      dec_ready = 1'b0;
    end
  end

  assign scan_stamp = rd_s_r[scan_idx_r];
  assign scan_less  = scan_stamp < best_r;

  assign slot_free   = !out_valid_r || pop_i;
  assign commit_used = (state_r == ST_LOOK) ? dec_used : used_r;
  assign commit_hit  = (state_r == ST_LOOK) ? look_hit : hit_r;
  assign commit      = (((state_r == ST_LOOK) && dec_ready) || (state_r == ST_COMMIT))
                       && slot_free;

  // Updated row for the way that hit or was filled.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      wr_v[w] = rd_v_r[w];
      wr_t[w] = rd_t_r[w];
      wr_s[w] = rd_s_r[w];
      if (WAY_W'(w) == commit_used) begin
        wr_v[w] = 1'b1;
        if (!commit_hit) begin
          wr_t[w] = cur_tag_r;
        end
        if ((mode_i == MODE_FIFO) && !commit_hit) begin
          wr_s[w] = fill_r;
        end else if (mode_i == MODE_LRU) begin
          wr_s[w] = access_r;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    used_nxt      = used_r;
    hit_nxt       = hit_r;
    best_nxt      = best_r;
    scan_idx_nxt  = scan_idx_r;
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    fill_nxt      = fill_r;
    access_nxt    = access_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    req_take_o    = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = cur_set_r;

    if (pop_i) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SET_W'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          req_take_o = 1'b1;
          rd_en      = 1'b1;
          state_nxt  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        hit_nxt  = look_hit;
        used_nxt = dec_used;
        if (dec_ready) begin
          state_nxt = slot_free ? ST_IDLE : ST_COMMIT;
        end else begin
          best_nxt     = rd_s_r[0];
          used_nxt     = '0;
          scan_idx_nxt = WAY_W'(1);
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_less) begin
          best_nxt = scan_stamp;
          used_nxt = scan_idx_r;
        end
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (scan_idx_r == WAY_W'(WAYS - 1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (commit) begin
      mem_we = 1'b1;
      if (commit_hit) begin
        hits_nxt = hits_r + 1'b1;
      end else begin
        misses_nxt = misses_r + 1'b1;
      end
      if ((mode_i == MODE_FIFO) && !commit_hit) begin
        fill_nxt = fill_r + 1'b1;
      end
      if (mode_i == MODE_LRU) begin
        access_nxt = access_r + 1'b1;
      end
      out_valid_nxt          = 1'b1;
      out_res_nxt.hit        = commit_hit;
      out_res_nxt.way        = OUT_WAY_W'(commit_used);
      out_res_nxt.hit_count  = hits_nxt;
      out_res_nxt.miss_count = misses_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      fill_r      <= '0;
      access_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      fill_r      <= fill_nxt;
      access_r    <= access_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    used_r     <= used_nxt;
    hit_r      <= hit_nxt;
    best_r     <= best_nxt;
    scan_idx_r <= scan_idx_nxt;
    out_res_r  <= out_res_nxt;
    if (req_take_o) begin
      cur_set_r  <= req_set_i;
      cur_tag_r  <= req_tag_i;
      cur_rway_r <= req_rway_i;
    end
  end

  // Row memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_v[mem_addr] <= (state_r == ST_CLEAR) ? '0 : wr_v;
      mem_t[mem_addr] <= (state_r == ST_CLEAR) ? '0 : wr_t;
      mem_s[mem_addr] <= (state_r == ST_CLEAR) ? '0 : wr_s;
    end
    if (rd_en) begin
      rd_v_r <= mem_v[req_set_i];
      rd_t_r <= mem_t[req_set_i];
      rd_s_r <= mem_s[req_set_i];
    end
  end

  assign clearing_o  = (state_r == ST_CLEAR);
  assign out_valid_o = out_valid_r;
  assign out_res_o   = out_res_r;

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !req_take_o)
    else $error("request taken while the tag store is being cleared");

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed request did not reach the result register");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (CNT_W'(hits_r + misses_r) == CNT_W'($past(hits_r + misses_r) + 1'b1)))
    else $error("hit and miss totals did not advance by one on commit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop_i) |=> $stable(out_res_r))
    else $error("waiting result was overwritten");

endmodule

@@ sv/set_assoc_cache_lookup.sv @@
`timescale 1ns / 1ps

// Channel   Handshake                       Payload
// request   push / full                     in_address, in_random_way
// result    empty / pop                     out_hit, out_way, out_hit_count, out_miss_count
// config    psel, penable, pwrite / pready  paddr, pwdata, prdata (replace_mode at 0x0)
//
// In the back end a lookup first reads the set's row from the tag memory, then
// compares the tags, picks the way and writes the row back.
// When a FIFO or LRU eviction is needed with more than one way, a stamp scan
// runs first, one stamp compare per cycle, and the row is then written back in
// a separate commit state.
// After reset the tag memory is cleared one set per cycle while full stays
// high; configuration writes are taken during that pass.
// A two-entry request queue keeps taking lookups while a result waits to be
// popped; the back end holds a finished lookup until the result slot frees.

module set_assoc_cache_lookup #(
  parameter int WAYS        = sacl_pkg::DEF_WAYS,
  parameter int SETS        = sacl_pkg::DEF_SETS,
  parameter int BLOCK_BYTES = sacl_pkg::DEF_BLOCK_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request side.
  input  logic                            push,
  output logic                            full,
  input  logic [sacl_pkg::ADDR_W-1:0]     in_address,
  input  logic [sacl_pkg::RWAY_W-1:0]     in_random_way,
  // Result side.
  output logic                            empty,
  input  logic                            pop,
  output logic                            out_hit,
  output logic [sacl_pkg::OUT_WAY_W-1:0]  out_way,
  output logic [sacl_pkg::CNT_W-1:0]      out_hit_count,
  output logic [sacl_pkg::CNT_W-1:0]      out_miss_count,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sacl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sacl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import sacl_pkg::*;

  localparam int OFF   = 2 + $clog2(BLOCK_BYTES / 4);
  localparam int IBITS = $clog2(SETS);
  localparam int SET_W = (IBITS > 0) ? IBITS : 1;
  localparam int TAG_W = 32 - OFF - IBITS;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              cfg_wr;
  logic              cfg_sel_mode;

  logic              req_valid;
  logic              req_take;
  logic [SET_W-1:0]  req_set;
  logic [TAG_W-1:0]  req_tag;
  logic [WAY_W-1:0]  req_rway;
  logic              clearing;
  logic              res_valid;
  res_t              res;

  // The only register is replace_mode, selected by paddr[2] low; writes with paddr[2] high are dropped.
  assign pready       = 1'b1;
  assign cfg_sel_mode = (paddr[CFG_ADDR_W-1:2] == REG_MODE);
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign prdata       = cfg_sel_mode ? CFG_DATA_W'(mode_r) : '0;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && cfg_sel_mode) begin
      mode_nxt = pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIFO;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // The front end splits the address and queues the request.
  sacl_front #(
    .WAYS        (WAYS),
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .block_i      (clearing),
    .full_o       (full),
    .address_i    (in_address),
    .random_way_i (in_random_way),
    .req_valid_o  (req_valid),
    .req_take_i   (req_take),
    .req_set_o    (req_set),
    .req_tag_o    (req_tag),
    .req_rway_o   (req_rway)
  );

  // The back end owns the tag memory, the stamps and the running totals.
  sacl_back #(
    .WAYS        (WAYS),
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode_i      (mode_r),
    .req_valid_i (req_valid),
    .req_set_i   (req_set),
    .req_tag_i   (req_tag),
    .req_rway_i  (req_rway),
    .req_take_o  (req_take),
    .clearing_o  (clearing),
    .pop_i       (pop),
    .out_valid_o (res_valid),
    .out_res_o   (res)
  );

  assign empty          = !res_valid;
  assign out_hit        = res.hit;
  assign out_way        = res.way;
  assign out_hit_count  = res.hit_count;
  assign out_miss_count = res.miss_count;

endmodule
